/* hw/rtl/strh_pkg.sv */
`default_nettype none
package strh_pkg;

	localparam int HW = 30;
	localparam int FW = 11;
	localparam int MAX_LEN_DEF = 1024;
	localparam logic [31:0] HASH_MOD = 32'd1000000007;
	localparam logic [31:0] HASH_BASE = 32'd1777771;
	localparam logic REG_STRING_LENGTH = 1'b0;

	typedef logic [HW-1:0] hash_t;

	// (a + b) mod P for a, b < P
	function automatic hash_t addmod(input hash_t a, input hash_t b);
		logic [HW:0] s;
		logic [HW:0] d;
		s = {1'b0, a} + {1'b0, b};
		d = s - (HW+1)'(HASH_MOD);
		return (s >= (HW+1)'(HASH_MOD)) ? d[HW-1:0] : s[HW-1:0];
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/strh_ram.sv */
`default_nettype none
module strh_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/strh_modmul.sv */
`default_nettype none
module strh_modmul import strh_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire hash_t a,
	input  wire hash_t b,
	output      logic  busy,
	output      logic  done,
	output      hash_t result
);

	localparam int CNTW = $clog2(HW + 1);

	hash_t           a_q;
	hash_t           b_q;
	hash_t           r_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	hash_t           dbl;
	hash_t           nxt;

	// MSB-first double-and-add, one multiplier bit per cycle
	always_comb begin
		dbl = addmod(r_q, r_q);
		nxt = b_q[HW-1] ? addmod(dbl, a_q) : dbl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(HW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= nxt;
			b_q <= {b_q[HW-2:0], 1'b0};
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = r_q;

endmodule
`default_nettype wire

/* hw/rtl/segment_tree_range_hash.sv */
// Channel | Direction | Signals                                     | Moves
// apb     | in        | psel penable pwrite paddr pwdata prdata     | string_length
// req     | in        | req_valid req_ready req_type position ...   | write or query
// rsp     | out       | rsp_valid rsp_ready range_hash              | query hash
// Every modular multiply runs on one bit-serial unit.
// A write walks down to its leaf, then updates each tree level on the way back up; a query
// multiplies once per covering node and only visits the other nodes.
// After reset: power table fill (one entry per multiply) and a clearing pass over all
// 4*MAX_LEN tree entries; writing string_length starts the clearing pass again.
// req_ready is low while an item, the fill or the clear runs; a stalled result blocks
// the next query only at its final transfer.
`default_nettype none
module segment_tree_range_hash import strh_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [2:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output      logic [31:0]          prdata,
	output      logic                 pready,
	input  wire logic                 req_valid,
	output      logic                 req_ready,
	input  wire logic                 req_type,
	input  wire logic [FW-1:0]        position,
	input  wire logic [FW-1:0]        right_end,
	input  wire logic signed [7:0]    char_value,
	output      logic                 rsp_valid,
	input  wire logic                 rsp_ready,
	output      logic [HW-1:0]        range_hash
);

	localparam int TREE_DEPTH = 4 * MAX_LEN;
	localparam int NW  = $clog2(TREE_DEPTH);
	localparam int PD  = MAX_LEN + 1;
	localparam int LW  = $clog2(PD);
	localparam int SD  = $clog2(MAX_LEN) + 1;
	localparam int SPW = $clog2(SD + 1);
	localparam int SIW = (SD > 1) ? $clog2(SD) : 1;

	localparam logic [3:0] ST_PINIT  = 4'd0;
	localparam logic [3:0] ST_PMUL   = 4'd1;
	localparam logic [3:0] ST_PWAIT  = 4'd2;
	localparam logic [3:0] ST_IDLE   = 4'd3;
	localparam logic [3:0] ST_WDOWN  = 4'd4;
	localparam logic [3:0] ST_WPOP   = 4'd5;
	localparam logic [3:0] ST_WRDL   = 4'd6;
	localparam logic [3:0] ST_WRDR   = 4'd7;
	localparam logic [3:0] ST_WMUL   = 4'd8;
	localparam logic [3:0] ST_QVISIT = 4'd9;
	localparam logic [3:0] ST_QMS    = 4'd10;
	localparam logic [3:0] ST_QMUL   = 4'd11;
	localparam logic [3:0] ST_QPOP   = 4'd12;
	localparam logic [3:0] ST_OUT    = 4'd13;

	logic [3:0]     state_q;
	logic [LW-1:0]  n_q;
	logic [NW-1:0]  clr_q;
	logic           clr_busy_q;
	logic [LW-1:0]  pidx_q;
	hash_t          pw_prev_q;
	logic [NW-1:0]  node_q;
	logic [LW-1:0]  lo_q;
	logic [LW-1:0]  hi_q;
	logic [LW-1:0]  pos_q;
	logic [LW-1:0]  qa_q;
	logic [LW-1:0]  qb_q;
	hash_t          val_q;
	hash_t          acc_q;
	logic [SPW-1:0] sp_q;
	logic [NW-1:0]  stk_node_q [SD];
	logic [LW-1:0]  stk_lo_q [SD];
	logic [LW-1:0]  stk_hi_q [SD];
	logic           rsp_valid_q;
	hash_t          range_hash_q;

	logic [LW:0]    mid_w;
	logic [LW-1:0]  mid;
	logic [NW-1:0]  node_l;
	logic [NW-1:0]  node_r;
	logic [SPW-1:0] sp_m1;
	logic [SIW-1:0] top_idx;
	logic [SIW-1:0] push_idx;
	logic           disjoint;
	logic           covered;
	logic           cfg_wr;
	logic [FW-1:0]  cfg_v;
	logic [31:0]    qa_w;
	logic [31:0]    qb_w;
	logic [31:0]    code_w;
	hash_t          residue;
	logic           wr_ok;

	logic           tree_we;
	logic [NW-1:0]  tree_waddr;
	hash_t          tree_wdata;
	logic           tree_re;
	logic [NW-1:0]  tree_raddr;
	hash_t          tree_rdata;
	logic           pow_we;
	logic [LW-1:0]  pow_waddr;
	hash_t          pow_wdata;
	logic           pow_re;
	logic [LW-1:0]  pow_raddr;
	hash_t          pow_rdata;
	logic           mul_start;
	hash_t          mul_a;
	hash_t          mul_b;
	logic           mul_busy;
	logic           mul_done;
	hash_t          mul_res;

	always_comb begin
		mid_w    = ({1'b0, lo_q} + {1'b0, hi_q}) >> 1;
		mid      = mid_w[LW-1:0];
		node_l   = {node_q[NW-2:0], 1'b0};
		node_r   = {node_q[NW-2:0], 1'b1};
		sp_m1    = sp_q - SPW'(1);
		top_idx  = sp_m1[SIW-1:0];
		push_idx = sp_q[SIW-1:0];
		disjoint = (hi_q < qa_q) || (qb_q < lo_q);
		covered  = (qa_q <= lo_q) && (hi_q <= qb_q);
		cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_STRING_LENGTH);
		cfg_v    = pwdata[FW-1:0];
		qa_w     = (position == '0) ? 32'd1 : 32'(position);
		qb_w     = (32'(right_end) > 32'(n_q)) ? 32'(n_q) : 32'(right_end);
		code_w   = 32'($unsigned(char_value));
		residue  = char_value[7] ? HW'(HASH_MOD - (32'd256 - code_w)) : HW'(code_w);
		wr_ok    = (position != '0) && (32'(position) <= 32'(n_q));
	end

	// RAM and multiplier port steering
	always_comb begin
		tree_we    = 1'b0;
		tree_waddr = node_q;
		tree_wdata = val_q;
		tree_re    = 1'b0;
		tree_raddr = node_q;
		pow_we     = 1'b0;
		pow_waddr  = pidx_q;
		pow_wdata  = mul_res;
		pow_re     = 1'b0;
		pow_raddr  = LW'(n_q - hi_q);
		mul_start  = 1'b0;
		mul_a      = tree_rdata;
		mul_b      = pow_rdata;
		case (state_q)
			ST_PINIT: begin
				pow_we    = 1'b1;
				pow_waddr = '0;
				pow_wdata = HW'(1);
			end
			ST_PMUL: begin
				mul_start = 1'b1;
				mul_a     = pw_prev_q;
				mul_b     = HW'(HASH_BASE);
			end
			ST_PWAIT: begin
				pow_we = mul_done;
			end
			ST_WDOWN: begin
				tree_we = (lo_q == hi_q);
			end
			ST_WRDL: begin
				tree_re    = 1'b1;
				tree_raddr = node_l;
				pow_re     = 1'b1;
				pow_raddr  = LW'(hi_q - mid);
			end
			ST_WRDR: begin
				mul_start  = 1'b1;
				tree_re    = 1'b1;
				tree_raddr = node_r;
			end
			ST_WMUL: begin
				tree_we    = mul_done;
				tree_wdata = addmod(mul_res, tree_rdata);
			end
			ST_QVISIT: begin
				tree_re = 1'b1;
				pow_re  = 1'b1;
			end
			ST_QMS: begin
				mul_start = 1'b1;
			end
			default: begin
			end
		endcase
		if (clr_busy_q) begin
			tree_we    = 1'b1;
			tree_waddr = clr_q;
			tree_wdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_PINIT;
			n_q         <= LW'(1);
			clr_q       <= '0;
			clr_busy_q  <= 1'b1;
			pidx_q      <= '0;
			sp_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				if (cfg_v == '0) begin
					n_q <= LW'(1);
				end else if (32'(cfg_v) > 32'(MAX_LEN)) begin
					n_q <= LW'(MAX_LEN);
				end else begin
					n_q <= LW'(cfg_v);
				end
				clr_busy_q <= 1'b1;
				clr_q      <= '0;
			end else if (clr_busy_q) begin
				clr_q <= clr_q + NW'(1);
				if (clr_q == NW'(TREE_DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (state_q == ST_OUT && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_PINIT: begin
					pidx_q  <= LW'(1);
					state_q <= ST_PMUL;
				end
				ST_PMUL: begin
					state_q <= ST_PWAIT;
				end
				ST_PWAIT: begin
					if (mul_done) begin
						if (pidx_q == LW'(MAX_LEN)) begin
							state_q <= ST_IDLE;
						end else begin
							pidx_q  <= pidx_q + LW'(1);
							state_q <= ST_PMUL;
						end
					end
				end
				ST_IDLE: begin
					if (req_valid && req_ready) begin
						node_q <= NW'(1);
						lo_q   <= LW'(1);
						hi_q   <= n_q;
						sp_q   <= '0;
						acc_q  <= '0;
						if (!req_type) begin
							if (wr_ok) begin
								state_q <= ST_WDOWN;
							end
						end else if (qa_w > qb_w) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_QVISIT;
						end
					end
				end
				ST_WDOWN: begin
					if (lo_q == hi_q) begin
						state_q <= ST_WPOP;
					end else begin
						sp_q <= sp_q + SPW'(1);
						if (pos_q <= mid) begin
							node_q <= node_l;
							hi_q   <= mid;
						end else begin
							node_q <= node_r;
							lo_q   <= mid + LW'(1);
						end
					end
				end
				ST_WPOP: begin
					if (sp_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						sp_q    <= sp_m1;
						node_q  <= stk_node_q[top_idx];
						lo_q    <= stk_lo_q[top_idx];
						hi_q    <= stk_hi_q[top_idx];
						state_q <= ST_WRDL;
					end
				end
				ST_WRDL: begin
					state_q <= ST_WRDR;
				end
				ST_WRDR: begin
					state_q <= ST_WMUL;
				end
				ST_WMUL: begin
					if (mul_done) begin
						state_q <= ST_WPOP;
					end
				end
				ST_QVISIT: begin
					if (disjoint) begin
						state_q <= ST_QPOP;
					end else if (covered) begin
						state_q <= ST_QMS;
					end else begin
						// right half goes on the stack, walk into the left half
						sp_q   <= sp_q + SPW'(1);
						node_q <= node_l;
						hi_q   <= mid;
					end
				end
				ST_QMS: begin
					state_q <= ST_QMUL;
				end
				ST_QMUL: begin
					if (mul_done) begin
						acc_q   <= addmod(acc_q, mul_res);
						state_q <= ST_QPOP;
					end
				end
				ST_QPOP: begin
					if (sp_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						sp_q    <= sp_m1;
						node_q  <= stk_node_q[top_idx];
						lo_q    <= stk_lo_q[top_idx];
						hi_q    <= stk_hi_q[top_idx];
						state_q <= ST_QVISIT;
					end
				end
				ST_OUT: begin
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PINIT) begin
			pw_prev_q <= HW'(1);
		end else if (state_q == ST_PWAIT && mul_done) begin
			pw_prev_q <= mul_res;
		end
		if (state_q == ST_IDLE && req_valid && req_ready) begin
			pos_q <= LW'(position);
			val_q <= residue;
			qa_q  <= LW'(qa_w);
			qb_q  <= LW'(qb_w);
		end
		if (state_q == ST_WDOWN && lo_q != hi_q) begin
			stk_node_q[push_idx] <= node_q;
			stk_lo_q[push_idx]   <= lo_q;
			stk_hi_q[push_idx]   <= hi_q;
		end
		if (state_q == ST_QVISIT && !disjoint && !covered) begin
			stk_node_q[push_idx] <= node_r;
			stk_lo_q[push_idx]   <= mid + LW'(1);
			stk_hi_q[push_idx]   <= hi_q;
		end
		if (state_q == ST_OUT && (!rsp_valid_q || rsp_ready)) begin
			range_hash_q <= acc_q;
		end
	end

	strh_ram #(
		.WIDTH (HW),
		.DEPTH (TREE_DEPTH)
	) u_tree_ram (
		.clk   (clk),
		.we    (tree_we),
		.waddr (tree_waddr),
		.wdata (tree_wdata),
		.re    (tree_re),
		.raddr (tree_raddr),
		.rdata (tree_rdata)
	);

	strh_ram #(
		.WIDTH (HW),
		.DEPTH (PD)
	) u_pow_ram (
		.clk   (clk),
		.we    (pow_we),
		.waddr (pow_waddr),
		.wdata (pow_wdata),
		.re    (pow_re),
		.raddr (pow_raddr),
		.rdata (pow_rdata)
	);

	strh_modmul u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.done   (mul_done),
		.result (mul_res)
	);

	assign req_ready  = (state_q == ST_IDLE) && !clr_busy_q;
	assign rsp_valid  = rsp_valid_q;
	assign range_hash = range_hash_q;
	assign prdata     = 32'(n_q);
	assign pready     = 1'b1;

`ifndef SYNTHESIS
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(sp_q) <= 32'(SD))
		else $error("tree walk stack overflow");

	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> (state_q == ST_IDLE || state_q == ST_PINIT ||
			state_q == ST_PMUL || state_q == ST_PWAIT))
		else $error("tree cleared while an item is in flight");

	a_mul_free: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_busy)
		else $error("multiplier restarted while busy");

	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("result raised outside output state");
`endif

endmodule
`default_nettype wire
